// ----- design/rha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rha_pkg
// Shared constants, types and helper functions of the RGB histogram unit.
// ----------------------------------------------------------------------------
package rha_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int BIN_COUNT   = 256;
	localparam int BIN_W       = $clog2(BIN_COUNT);
	localparam int NUM_HIST    = 4;

	// Histogram slots in the datapath.
	localparam int HIST_RED   = 0;
	localparam int HIST_GREEN = 1;
	localparam int HIST_BLUE  = 2;
	localparam int HIST_VALUE = 3;

	// Function codes carried on the func port.
	localparam logic FUNC_ACCUM = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [OUT_WIDTH-1:0]   out_count_t;
	typedef logic [BIN_W-1:0]       bin_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic write_back;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_read;
	} dp_status_t;

	// Add one unless the counter already holds its maximum.
	function automatic count_t sat_inc(input count_t c);
		count_t sum;
		sum = c + count_t'(1);
		if (c == '1) begin
			return c;
		end
		return sum;
	endfunction

	// A count too large for the output field is reported as the field maximum.
	function automatic out_count_t clip_count(input count_t c);
		logic [63:0] wide;
		wide = 64'(c);
		if (wide > 64'({OUT_WIDTH{1'b1}})) begin
			return '1;
		end
		return wide[OUT_WIDTH-1:0];
	endfunction

endpackage

// ----- design/rha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/rha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rha_ctrl
// Controller: clears the bins after reset, then sequences the read phase and
// the update phase of each item.
// ----------------------------------------------------------------------------
module rha_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  rha_pkg::dp_status_t   status,
	output logic                  busy,
	output rha_pkg::ctrl_cmd_t    cmd
);

	rha_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rha_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rha_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = rha_pkg::ST_IDLE;
				end
			end
			rha_pkg::ST_IDLE: begin
				if (start) begin
					state_d = rha_pkg::ST_UPDATE;
				end
			end
			rha_pkg::ST_UPDATE: begin
				state_d = rha_pkg::ST_IDLE;
			end
			default: begin
				state_d = rha_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = 1'b0;
		cmd.clear      = 1'b0;
		cmd.load       = 1'b0;
		cmd.write_back = 1'b0;
		cmd.emit       = 1'b0;
		unique case (state_q)
			rha_pkg::ST_CLEAR: begin
				busy      = 1'b1;
				cmd.clear = 1'b1;
			end
			rha_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			rha_pkg::ST_UPDATE: begin
				busy           = 1'b1;
				cmd.write_back = !status.is_read;
				cmd.emit       = status.is_read;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/rha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rha_datapath
// Four bin memories with a clearing pass, saturating update and result register.
// ----------------------------------------------------------------------------
module rha_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rha_pkg::ctrl_cmd_t         cmd,
	output rha_pkg::dp_status_t        status,
	input  logic                       func,
	input  logic [7:0]                 red_value,
	input  logic [7:0]                 green_value,
	input  logic [7:0]                 blue_value,
	input  logic [7:0]                 bin_index,
	output logic                       done,
	output rha_pkg::out_count_t        red_count,
	output rha_pkg::out_count_t        green_count,
	output rha_pkg::out_count_t        blue_count,
	output rha_pkg::out_count_t        value_count
);

	rha_pkg::bin_t   raddr    [rha_pkg::NUM_HIST];
	rha_pkg::bin_t   addr_s1  [rha_pkg::NUM_HIST];
	rha_pkg::bin_t   waddr    [rha_pkg::NUM_HIST];
	rha_pkg::count_t rdata    [rha_pkg::NUM_HIST];
	rha_pkg::count_t wdata    [rha_pkg::NUM_HIST];
	rha_pkg::bin_t   max_rg;
	rha_pkg::bin_t   max_rgb;
	rha_pkg::bin_t   clr_addr_q;
	logic ram_we;
	logic func_s1;
	logic done_q;
	rha_pkg::out_count_t counts_q [rha_pkg::NUM_HIST];

	assign max_rg  = (green_value > red_value) ? green_value : red_value;
	assign max_rgb = (blue_value > max_rg) ? blue_value : max_rg;

	// A read transaction addresses the same bin in all four histograms.
	always_comb begin
		if (func == rha_pkg::FUNC_READ) begin
			raddr[rha_pkg::HIST_RED]   = bin_index;
			raddr[rha_pkg::HIST_GREEN] = bin_index;
			raddr[rha_pkg::HIST_BLUE]  = bin_index;
			raddr[rha_pkg::HIST_VALUE] = bin_index;
		end else begin
			raddr[rha_pkg::HIST_RED]   = red_value;
			raddr[rha_pkg::HIST_GREEN] = green_value;
			raddr[rha_pkg::HIST_BLUE]  = blue_value;
			raddr[rha_pkg::HIST_VALUE] = max_rgb;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1 <= func;
			for (int h = 0; h < rha_pkg::NUM_HIST; h++) begin
				addr_s1[h] <= raddr[h];
			end
		end
	end

	assign status.is_read    = (func_s1 == rha_pkg::FUNC_READ);
	assign status.clear_last = (clr_addr_q == rha_pkg::bin_t'(rha_pkg::BIN_COUNT - 1));

	// After reset every bin is written with zero, one address per cycle.
	assign ram_we = cmd.write_back | cmd.clear;

	for (genvar h = 0; h < rha_pkg::NUM_HIST; h++) begin : g_hist
		assign waddr[h] = cmd.clear ? clr_addr_q : addr_s1[h];
		assign wdata[h] = cmd.clear ? '0 : rha_pkg::sat_inc(rdata[h]);

		rha_ram #(
			.WIDTH(rha_pkg::COUNT_WIDTH),
			.DEPTH(rha_pkg::BIN_COUNT)
		) u_ram (
			.clk  (clk),
			.we   (ram_we),
			.waddr(waddr[h]),
			.wdata(wdata[h]),
			.re   (cmd.load),
			.raddr(raddr[h]),
			.rdata(rdata[h])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + rha_pkg::bin_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int h = 0; h < rha_pkg::NUM_HIST; h++) begin
				counts_q[h] <= rha_pkg::clip_count(rdata[h]);
			end
		end
	end

	assign done        = done_q;
	assign red_count   = counts_q[rha_pkg::HIST_RED];
	assign green_count = counts_q[rha_pkg::HIST_GREEN];
	assign blue_count  = counts_q[rha_pkg::HIST_BLUE];
	assign value_count = counts_q[rha_pkg::HIST_VALUE];

endmodule

// ----- design/rgb_histogram_accumulator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_histogram_accumulator_unit
// Red, green, blue and value histograms of 256 bins with saturating counts.
// ----------------------------------------------------------------------------
// Transactions: a new transaction is not accepted until the last one has been written
// back; the bin memories are read in the accept cycle and written in the cycle after.
// Results: done rises only for a bin read; done and the counts are registered from
// the update state in the same cycle; the receiver cannot stall.
// Reset: busy stays high after reset while a clearing pass writes zero to every bin,
// one address per cycle; then the first transaction is accepted.
module rgb_histogram_accumulator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [7:0]          red_value,
	input  logic [7:0]          green_value,
	input  logic [7:0]          blue_value,
	input  logic [7:0]          bin_index,
	output logic                done,
	output rha_pkg::out_count_t red_count,
	output rha_pkg::out_count_t green_count,
	output rha_pkg::out_count_t blue_count,
	output rha_pkg::out_count_t value_count
);

	rha_pkg::ctrl_cmd_t  cmd;
	rha_pkg::dp_status_t status;

	rha_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	rha_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.func       (func),
		.red_value  (red_value),
		.green_value(green_value),
		.blue_value (blue_value),
		.bin_index  (bin_index),
		.done       (done),
		.red_count  (red_count),
		.green_count(green_count),
		.blue_count (blue_count),
		.value_count(value_count)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == rha_pkg::FUNC_READ) |=> ##1 done)
		else $error("bin read produced no result");

	a_no_result_for_accum: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == rha_pkg::FUNC_ACCUM) |=> ##1 !done)
		else $error("pixel accumulate produced a result");

endmodule
